[hw/rtl/pmst_pkg.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator package
// Shared widths, register codes, fixed-point constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package pmst_pkg;

    // Field widths
    localparam int IDX_W   = 12;
    localparam int SEG_W   = 13;
    localparam int RAD_W   = 31;
    localparam int MASK_W  = 6;
    localparam int COORD_W = 32;
    localparam int TRIG_W  = 32;
    localparam int PROD_W  = 64;

    // APB register map
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_INNER_RADIUS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENTS     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FACE_MASK    = 3'd4;

    localparam logic [RAD_W-1:0]  RESET_INNER_RADIUS = 31'd65536;
    localparam logic [RAD_W-1:0]  RESET_OUTER_RADIUS = 31'd131072;
    localparam logic [RAD_W-1:0]  RESET_HEIGHT       = 31'd65536;
    localparam logic [SEG_W-1:0]  RESET_SEGMENTS     = 13'd32;
    localparam logic [MASK_W-1:0] RESET_FACE_MASK    = 6'd63;

    localparam logic [SEG_W-1:0] MIN_SEGMENTS = 13'd3;
    localparam logic [SEG_W-1:0] MAX_SEGMENTS = 13'd4096;

    // Phase generation: a full turn is 2^ANGLE_BITS.
    localparam int ANGLE_BITS = 16;
    localparam int QUAD_BITS  = ANGLE_BITS - 2;
    localparam int NUM_W      = SEG_W + 1;
    localparam int REM_W      = NUM_W + 1;
    localparam int QUO_W      = ANGLE_BITS + 1;
    localparam int DIV_LAT    = QUO_W;

    // CORDIC
    localparam int XY_W            = 34;
    localparam int Z_W             = 33;
    localparam int HP_W            = 31;
    localparam int CORDIC_ITERS    = 30;
    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
    localparam int SC_LAT          = CORDIC_STAGES + 2;

    localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XY_W-1:0]   Q30_ONE     = 34'sd1073741824;
    localparam logic [HP_W-1:0]          HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [PROD_W-1:0] ROUND_Q30   = 64'sd536870912;
    localparam int                       FRAC_SHIFT  = 30;

    typedef logic [ANGLE_BITS-1:0]    phase_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Arctangent of 2^-k in Q2.30 radians.
    function automatic logic signed [Z_W-1:0] atan_step(input int k);
        logic signed [Z_W-1:0] t;
        case (k)
            0:       t = 33'sd843314856;
            1:       t = 33'sd497837829;
            2:       t = 33'sd263043836;
            3:       t = 33'sd133525158;
            4:       t = 33'sd67021686;
            5:       t = 33'sd33543515;
            6:       t = 33'sd16775850;
            7:       t = 33'sd8388437;
            8:       t = 33'sd4194282;
            9:       t = 33'sd2097149;
            default: t = Z_W'((64'sd1 <<< (30 - k)) - 64'sd1);
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/pmst_if.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator channels
// Valid/ready channels for segment indexes and for facet results.
// ----------------------------------------------------------------------------
interface pmst_in_if;
    logic                        valid;
    logic                        ready;
    logic [pmst_pkg::IDX_W-1:0] segment_index;

    modport source (output valid, output segment_index, input ready);
    modport sink   (input valid, input segment_index, output ready);
endinterface

interface pmst_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [31:0]            normal_x;
    logic signed [31:0]            normal_y;
    logic signed [1:0]             normal_z;
    logic signed [31:0]            vert0_x;
    logic signed [31:0]            vert0_y;
    logic signed [31:0]            vert1_x;
    logic signed [31:0]            vert1_y;
    logic signed [31:0]            vert2_x;
    logic signed [31:0]            vert2_y;
    logic [2:0]                    z_signs;
    logic                          config_error;
    logic                          last_of_run;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output vert0_x, output vert0_y, output vert1_x, output vert1_y,
                    output vert2_x, output vert2_y, output z_signs,
                    output config_error, output last_of_run, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input vert0_x, input vert0_y, input vert1_x, input vert1_y,
                    input vert2_x, input vert2_y, input z_signs,
                    input config_error, input last_of_run, output ready);
endinterface

[hw/rtl/pmst_div.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator phase divider
// Pipelined restoring divider giving floor(num * 2^ANGLE_BITS / den), one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module pmst_div
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [pmst_pkg::NUM_W-1:0]   num,
    input  logic [pmst_pkg::NUM_W-1:0]   den,
    output logic [pmst_pkg::QUO_W-1:0]   quo
);

    logic [pmst_pkg::REM_W-1:0] rem_reg [pmst_pkg::DIV_LAT];
    logic [pmst_pkg::QUO_W-1:0] quo_reg [pmst_pkg::DIV_LAT];

    genvar s;
    for (s = 0; s < pmst_pkg::DIV_LAT; s++)
    begin : g_step
        logic [pmst_pkg::REM_W-1:0] trial;
        logic [pmst_pkg::REM_W-1:0] rem_next;
        logic [pmst_pkg::QUO_W-1:0] quo_next;
        logic                       ge;

        // The first step yields the integer bit, the rest the fraction bits.
        if (s == 0)
        begin : g_first
            always_comb
            begin
                trial    = pmst_pkg::REM_W'(num);
                ge       = trial >= pmst_pkg::REM_W'(den);
                rem_next = ge ? trial - pmst_pkg::REM_W'(den) : trial;
                quo_next = pmst_pkg::QUO_W'(ge);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                trial    = {rem_reg[s-1][pmst_pkg::REM_W-2:0], 1'b0};
                ge       = trial >= pmst_pkg::REM_W'(den);
                rem_next = ge ? trial - pmst_pkg::REM_W'(den) : trial;
                quo_next = {quo_reg[s-1][pmst_pkg::QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[pmst_pkg::DIV_LAT-1];

endmodule

[hw/rtl/pmst_sincos.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator sine and cosine
// Quadrant reduction, a 30-step CORDIC at two steps per stage, then clamping
// and quadrant mapping. Results are Q2.30.
// ----------------------------------------------------------------------------
module pmst_sincos
(
    input  logic             clk,
    input  logic             en,
    input  pmst_pkg::phase_t phase,
    output pmst_pkg::trig_t  cos_val,
    output pmst_pkg::trig_t  sin_val
);

    localparam int NS = pmst_pkg::CORDIC_STAGES;

    logic [1:0]                        quad_reg [NS + 1];
    logic signed [pmst_pkg::XY_W-1:0]  x_reg    [NS + 1];
    logic signed [pmst_pkg::XY_W-1:0]  y_reg    [NS + 1];
    logic signed [pmst_pkg::Z_W-1:0]   z_reg    [NS + 1];

    logic [pmst_pkg::QUAD_BITS+pmst_pkg::HP_W-1:0] z_prod;
    pmst_pkg::trig_t cos_reg;
    pmst_pkg::trig_t sin_reg;

    // Angle within the quadrant, scaled to radians in Q2.30.
    assign z_prod = (pmst_pkg::QUAD_BITS+pmst_pkg::HP_W)'(phase[pmst_pkg::QUAD_BITS-1:0])
                  * (pmst_pkg::QUAD_BITS+pmst_pkg::HP_W)'(pmst_pkg::HALF_PI_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= phase[pmst_pkg::ANGLE_BITS-1 -: 2];
            x_reg[0]    <= pmst_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= pmst_pkg::Z_W'(z_prod >> pmst_pkg::QUAD_BITS);
        end
    end

    genvar s;
    for (s = 1; s <= NS; s++)
    begin : g_stage
        logic signed [pmst_pkg::XY_W-1:0] x_next;
        logic signed [pmst_pkg::XY_W-1:0] y_next;
        logic signed [pmst_pkg::Z_W-1:0]  z_next;

        always_comb
        begin
            logic signed [pmst_pkg::XY_W-1:0] dx;
            logic signed [pmst_pkg::XY_W-1:0] dy;
            logic signed [pmst_pkg::Z_W-1:0]  t;
            int                               k;
            x_next = x_reg[s-1];
            y_next = y_reg[s-1];
            z_next = z_reg[s-1];
            for (int j = 0; j < pmst_pkg::ITERS_PER_STAGE; j++)
            begin
                k  = (s - 1) * pmst_pkg::ITERS_PER_STAGE + j;
                t  = pmst_pkg::atan_step(k);
                dx = y_next >>> k;
                dy = x_next >>> k;
                if (z_next >= 0)
                begin
                    x_next = x_next - dx;
                    y_next = y_next + dy;
                    z_next = z_next - t;
                end
                else
                begin
                    x_next = x_next + dx;
                    y_next = y_next - dy;
                    z_next = z_next + t;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[s] <= quad_reg[s-1];
                x_reg[s]    <= x_next;
                y_reg[s]    <= y_next;
                z_reg[s]    <= z_next;
            end
        end
    end

    logic signed [pmst_pkg::XY_W-1:0] xc;
    logic signed [pmst_pkg::XY_W-1:0] yc;
    logic signed [pmst_pkg::XY_W-1:0] c_next;
    logic signed [pmst_pkg::XY_W-1:0] s_next;

    always_comb
    begin
        if (x_reg[NS] > pmst_pkg::Q30_ONE)
            xc = pmst_pkg::Q30_ONE;
        else if (x_reg[NS] < -pmst_pkg::Q30_ONE)
            xc = -pmst_pkg::Q30_ONE;
        else
            xc = x_reg[NS];

        if (y_reg[NS] > pmst_pkg::Q30_ONE)
            yc = pmst_pkg::Q30_ONE;
        else if (y_reg[NS] < -pmst_pkg::Q30_ONE)
            yc = -pmst_pkg::Q30_ONE;
        else
            yc = y_reg[NS];

        case (quad_reg[NS])
            2'd0:
            begin
                c_next = xc;
                s_next = yc;
            end
            2'd1:
            begin
                c_next = -yc;
                s_next = xc;
            end
            2'd2:
            begin
                c_next = -xc;
                s_next = -yc;
            end
            default:
            begin
                c_next = yc;
                s_next = -xc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= pmst_pkg::TRIG_W'(c_next);
            sin_reg <= pmst_pkg::TRIG_W'(s_next);
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

[hw/rtl/pipe_mesh_segment_tessellator.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator
// Throughput: one segment per cycle while each yields at most one result and
// the result port is ready; a segment with k results (k up to 10) holds the
// single result port until all k of them have been taken.
// Reset: rst_n clears the pipeline and loads the register defaults at once.
// ----------------------------------------------------------------------------
module pipe_mesh_segment_tessellator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmst_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmst_pkg::DATA_W-1:0]   pwdata,
    output logic [pmst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    pmst_in_if.sink                       in_ch,
    pmst_out_if.source                    out_ch
);

    localparam int PIPE_LEN = pmst_pkg::DIV_LAT + pmst_pkg::SC_LAT + 3;
    localparam int LAST     = PIPE_LEN - 1;
    localparam int NSLOT    = 10;
    localparam int NPT      = 8;

    localparam logic [3:0] SLOT_IN_TOP    = 4'd0;
    localparam logic [3:0] SLOT_OUT_TOP_A = 4'd1;
    localparam logic [3:0] SLOT_OUT_TOP_B = 4'd2;
    localparam logic [3:0] SLOT_IN_BOT    = 4'd3;
    localparam logic [3:0] SLOT_OUT_BOT_A = 4'd4;
    localparam logic [3:0] SLOT_OUT_BOT_B = 4'd5;
    localparam logic [3:0] SLOT_IN_SIDE_A = 4'd6;
    localparam logic [3:0] SLOT_IN_SIDE_B = 4'd7;
    localparam logic [3:0] SLOT_OUT_SIDE_A = 4'd8;
    localparam logic [3:0] SLOT_OUT_SIDE_B = 4'd9;

    // Ring point order: inner i, inner previous, outer i, outer previous.
    localparam int PT_IX  = 0;
    localparam int PT_IY  = 1;
    localparam int PT_IPX = 2;
    localparam int PT_IPY = 3;
    localparam int PT_OX  = 4;
    localparam int PT_OY  = 5;
    localparam int PT_OPX = 6;
    localparam int PT_OPY = 7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pmst_pkg::RAD_W-1:0]  inner_radius_reg;
    logic [pmst_pkg::RAD_W-1:0]  outer_radius_reg;
    logic [pmst_pkg::RAD_W-1:0]  height_reg;
    logic [pmst_pkg::SEG_W-1:0]  segments_reg;
    logic [pmst_pkg::MASK_W-1:0] face_mask_reg;
    logic [pmst_pkg::REG_IDX_W-1:0] reg_idx;
    logic                        cfg_write;

    assign reg_idx   = paddr[pmst_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg <= pmst_pkg::RESET_INNER_RADIUS;
            outer_radius_reg <= pmst_pkg::RESET_OUTER_RADIUS;
            height_reg       <= pmst_pkg::RESET_HEIGHT;
            segments_reg     <= pmst_pkg::RESET_SEGMENTS;
            face_mask_reg    <= pmst_pkg::RESET_FACE_MASK;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                pmst_pkg::REG_INNER_RADIUS: inner_radius_reg <= pwdata[pmst_pkg::RAD_W-1:0];
                pmst_pkg::REG_OUTER_RADIUS: outer_radius_reg <= pwdata[pmst_pkg::RAD_W-1:0];
                pmst_pkg::REG_HEIGHT:       height_reg       <= pwdata[pmst_pkg::RAD_W-1:0];
                pmst_pkg::REG_SEGMENTS:     segments_reg     <= pwdata[pmst_pkg::SEG_W-1:0];
                pmst_pkg::REG_FACE_MASK:    face_mask_reg    <= pwdata[pmst_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pmst_pkg::REG_INNER_RADIUS: prdata = pmst_pkg::DATA_W'(inner_radius_reg);
            pmst_pkg::REG_OUTER_RADIUS: prdata = pmst_pkg::DATA_W'(outer_radius_reg);
            pmst_pkg::REG_HEIGHT:       prdata = pmst_pkg::DATA_W'(height_reg);
            pmst_pkg::REG_SEGMENTS:     prdata = pmst_pkg::DATA_W'(segments_reg);
            pmst_pkg::REG_FACE_MASK:    prdata = pmst_pkg::DATA_W'(face_mask_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together when the result
    // register can take a new segment.
    // ------------------------------------------------------------------
    logic adv;
    logic gen_last;
    logic vld_reg [PIPE_LEN];
    logic rng_reg [1:PIPE_LEN-1];
    logic [pmst_pkg::IDX_W-1:0] idx_reg;

    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_LEN; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_ch.valid;
            for (int s = 1; s < PIPE_LEN; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    logic in_range;
    assign in_range = {1'b0, idx_reg} < segments_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg    <= in_ch.segment_index;
            rng_reg[1] <= in_range;
            for (int s = 2; s < PIPE_LEN; s++)
                rng_reg[s] <= rng_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Phases of the two ring points and of the mid angle
    // ------------------------------------------------------------------
    logic [pmst_pkg::IDX_W-1:0] prev_idx;
    logic [pmst_pkg::NUM_W-1:0] mid_num;
    logic [pmst_pkg::NUM_W-1:0] den_seg;
    logic [pmst_pkg::NUM_W-1:0] den_mid;
    logic [pmst_pkg::QUO_W-1:0] quo_i;
    logic [pmst_pkg::QUO_W-1:0] quo_p;
    logic [pmst_pkg::QUO_W-1:0] quo_m;

    assign prev_idx = (idx_reg == '0) ? pmst_pkg::IDX_W'(segments_reg - pmst_pkg::SEG_W'(1))
                                      : idx_reg - pmst_pkg::IDX_W'(1);
    assign den_seg  = pmst_pkg::NUM_W'(segments_reg);
    assign den_mid  = {segments_reg, 1'b0};
    assign mid_num  = pmst_pkg::NUM_W'({idx_reg, 1'b0}) + den_mid - pmst_pkg::NUM_W'(1);

    pmst_div u_div_i (.clk(clk), .en(adv), .num(pmst_pkg::NUM_W'(idx_reg)),
                      .den(den_seg), .quo(quo_i));
    pmst_div u_div_p (.clk(clk), .en(adv), .num(pmst_pkg::NUM_W'(prev_idx)),
                      .den(den_seg), .quo(quo_p));
    pmst_div u_div_m (.clk(clk), .en(adv), .num(mid_num),
                      .den(den_mid), .quo(quo_m));

    pmst_pkg::trig_t c_i, s_i, c_p, s_p, c_m, s_m;

    pmst_sincos u_sc_i (.clk(clk), .en(adv), .phase(quo_i[pmst_pkg::ANGLE_BITS-1:0]),
                        .cos_val(c_i), .sin_val(s_i));
    pmst_sincos u_sc_p (.clk(clk), .en(adv), .phase(quo_p[pmst_pkg::ANGLE_BITS-1:0]),
                        .cos_val(c_p), .sin_val(s_p));
    pmst_sincos u_sc_m (.clk(clk), .en(adv), .phase(quo_m[pmst_pkg::ANGLE_BITS-1:0]),
                        .cos_val(c_m), .sin_val(s_m));

    // ------------------------------------------------------------------
    // Ring coordinates: multiply, then round and rescale
    // ------------------------------------------------------------------
    logic signed [pmst_pkg::PROD_W-1:0] prod_reg  [NPT];
    pmst_pkg::coord_t                    coord_reg [NPT];
    pmst_pkg::trig_t                     trig_sel  [NPT];
    pmst_pkg::trig_t mid_c1_reg, mid_s1_reg, mid_c2_reg, mid_s2_reg;
    logic signed [31:0] r_inner;
    logic signed [31:0] r_outer;

    assign r_inner = {1'b0, inner_radius_reg};
    assign r_outer = {1'b0, outer_radius_reg};

    assign trig_sel[PT_IX]  = c_i;
    assign trig_sel[PT_IY]  = s_i;
    assign trig_sel[PT_IPX] = c_p;
    assign trig_sel[PT_IPY] = s_p;
    assign trig_sel[PT_OX]  = c_i;
    assign trig_sel[PT_OY]  = s_i;
    assign trig_sel[PT_OPX] = c_p;
    assign trig_sel[PT_OPY] = s_p;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NPT; k++)
            begin
                if (k < PT_OX)
                    prod_reg[k] <= pmst_pkg::PROD_W'(r_inner)
                                 * pmst_pkg::PROD_W'(trig_sel[k]);
                else
                    prod_reg[k] <= pmst_pkg::PROD_W'(r_outer)
                                 * pmst_pkg::PROD_W'(trig_sel[k]);
                coord_reg[k] <= pmst_pkg::COORD_W'((prod_reg[k] + pmst_pkg::ROUND_Q30)
                                                   >>> pmst_pkg::FRAC_SHIFT);
            end
            mid_c1_reg <= c_m;
            mid_s1_reg <= s_m;
            mid_c2_reg <= mid_c1_reg;
            mid_s2_reg <= mid_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register and facet sequencer
    // ------------------------------------------------------------------
    logic             cfg_err;
    logic [NSLOT-1:0] slots;
    logic             load_ok;

    assign cfg_err = (inner_radius_reg == '0) || (outer_radius_reg == '0)
                  || (outer_radius_reg < inner_radius_reg)
                  || (segments_reg < pmst_pkg::MIN_SEGMENTS)
                  || (segments_reg > pmst_pkg::MAX_SEGMENTS);

    assign slots = {face_mask_reg[5], face_mask_reg[5], face_mask_reg[4], face_mask_reg[4],
                    face_mask_reg[3], face_mask_reg[3], face_mask_reg[2],
                    face_mask_reg[1], face_mask_reg[1], face_mask_reg[0]};

    assign load_ok = vld_reg[LAST] && (cfg_err || (rng_reg[LAST] && (slots != '0)));

    logic             gen_vld_reg;
    logic             gen_err_reg;
    logic [NSLOT-1:0] gen_pend_reg;
    pmst_pkg::coord_t gen_pt_reg [NPT];
    pmst_pkg::trig_t  gen_c_reg;
    pmst_pkg::trig_t  gen_s_reg;
    logic [NSLOT-1:0] pend_rest;

    assign pend_rest = gen_pend_reg & (gen_pend_reg - NSLOT'(1));
    assign gen_last  = gen_err_reg || (pend_rest == '0);
    assign adv       = !gen_vld_reg || (out_ch.ready && gen_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_vld_reg  <= 1'b0;
            gen_err_reg  <= 1'b0;
            gen_pend_reg <= '0;
        end
        else if (adv)
        begin
            gen_vld_reg <= load_ok;
            if (load_ok)
            begin
                gen_err_reg  <= cfg_err;
                gen_pend_reg <= cfg_err ? '0 : slots;
            end
        end
        else if (out_ch.ready)
        begin
            // A facet other than the last one went out in this transfer.
            gen_pend_reg <= pend_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && load_ok)
        begin
            for (int k = 0; k < NPT; k++)
                gen_pt_reg[k] <= coord_reg[k];
            gen_c_reg <= mid_c2_reg;
            gen_s_reg <= mid_s2_reg;
        end
    end

    logic [3:0] slot;

    always_comb
    begin
        slot = SLOT_IN_TOP;
        for (int k = NSLOT - 1; k >= 0; k--)
        begin
            if (gen_pend_reg[k])
                slot = 4'(k);
        end
    end

    pmst_pkg::coord_t ix, iy, ipx, ipy, ox, oy, opx, opy;

    assign ix  = gen_pt_reg[PT_IX];
    assign iy  = gen_pt_reg[PT_IY];
    assign ipx = gen_pt_reg[PT_IPX];
    assign ipy = gen_pt_reg[PT_IPY];
    assign ox  = gen_pt_reg[PT_OX];
    assign oy  = gen_pt_reg[PT_OY];
    assign opx = gen_pt_reg[PT_OPX];
    assign opy = gen_pt_reg[PT_OPY];

    always_comb
    begin
        out_ch.normal_x = '0;
        out_ch.normal_y = '0;
        out_ch.normal_z = '0;
        out_ch.vert0_x  = '0;
        out_ch.vert0_y  = '0;
        out_ch.vert1_x  = '0;
        out_ch.vert1_y  = '0;
        out_ch.vert2_x  = '0;
        out_ch.vert2_y  = '0;
        out_ch.z_signs  = '0;
        if (!gen_err_reg)
        begin
            unique case (slot)
                SLOT_IN_TOP, SLOT_IN_BOT:
                begin
                    out_ch.vert1_x = ix;
                    out_ch.vert1_y = iy;
                    out_ch.vert2_x = ipx;
                    out_ch.vert2_y = ipy;
                end
                SLOT_OUT_TOP_A, SLOT_OUT_BOT_A:
                begin
                    out_ch.vert0_x = ix;
                    out_ch.vert0_y = iy;
                    out_ch.vert1_x = ipx;
                    out_ch.vert1_y = ipy;
                    out_ch.vert2_x = ox;
                    out_ch.vert2_y = oy;
                end
                SLOT_OUT_TOP_B, SLOT_OUT_BOT_B:
                begin
                    out_ch.vert0_x = ipx;
                    out_ch.vert0_y = ipy;
                    out_ch.vert1_x = opx;
                    out_ch.vert1_y = opy;
                    out_ch.vert2_x = ox;
                    out_ch.vert2_y = oy;
                end
                SLOT_IN_SIDE_A:
                begin
                    out_ch.vert0_x = ix;
                    out_ch.vert0_y = iy;
                    out_ch.vert1_x = ipx;
                    out_ch.vert1_y = ipy;
                    out_ch.vert2_x = ix;
                    out_ch.vert2_y = iy;
                end
                SLOT_IN_SIDE_B:
                begin
                    out_ch.vert0_x = ipx;
                    out_ch.vert0_y = ipy;
                    out_ch.vert1_x = ipx;
                    out_ch.vert1_y = ipy;
                    out_ch.vert2_x = ix;
                    out_ch.vert2_y = iy;
                end
                SLOT_OUT_SIDE_A:
                begin
                    out_ch.vert0_x = ox;
                    out_ch.vert0_y = oy;
                    out_ch.vert1_x = opx;
                    out_ch.vert1_y = opy;
                    out_ch.vert2_x = ox;
                    out_ch.vert2_y = oy;
                end
                SLOT_OUT_SIDE_B:
                begin
                    out_ch.vert0_x = opx;
                    out_ch.vert0_y = opy;
                    out_ch.vert1_x = opx;
                    out_ch.vert1_y = opy;
                    out_ch.vert2_x = ox;
                    out_ch.vert2_y = oy;
                end
                default: ;
            endcase

            unique case (slot)
                SLOT_IN_TOP, SLOT_OUT_TOP_A, SLOT_OUT_TOP_B:
                begin
                    out_ch.normal_z = 2'sd1;
                end
                SLOT_IN_BOT, SLOT_OUT_BOT_A, SLOT_OUT_BOT_B:
                begin
                    out_ch.normal_z = -2'sd1;
                    out_ch.z_signs  = 3'b111;
                end
                SLOT_IN_SIDE_A, SLOT_IN_SIDE_B:
                begin
                    // Inner side faces the axis.
                    out_ch.normal_x = -gen_c_reg;
                    out_ch.normal_y = -gen_s_reg;
                    out_ch.z_signs  = (slot == SLOT_IN_SIDE_A) ? 3'b100 : 3'b110;
                end
                SLOT_OUT_SIDE_A, SLOT_OUT_SIDE_B:
                begin
                    out_ch.normal_x = gen_c_reg;
                    out_ch.normal_y = gen_s_reg;
                    out_ch.z_signs  = (slot == SLOT_OUT_SIDE_A) ? 3'b100 : 3'b110;
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid        = gen_vld_reg;
    assign out_ch.config_error = gen_err_reg;
    assign out_ch.last_of_run  = gen_last;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Pipe mesh segment tessellator testbench
// Drives segment indexes and register writes, predicts every facet with an
// independent fixed-point CORDIC model and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [1:0]  normal_z;
        logic signed [31:0] v0x;
        logic signed [31:0] v0y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic [2:0]         z_signs;
        logic               config_error;
        logic               last_of_run;
    } facet_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [pmst_pkg::ADDR_W-1:0] paddr;
    logic [pmst_pkg::DATA_W-1:0] pwdata;
    logic [pmst_pkg::DATA_W-1:0] prdata;
    logic pready;

    pmst_in_if  in_ch();
    pmst_out_if out_ch();

    pipe_mesh_segment_tessellator u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Shadow copy of the register file.
    logic [pmst_pkg::RAD_W-1:0]  sh_inner;
    logic [pmst_pkg::RAD_W-1:0]  sh_outer;
    logic [pmst_pkg::RAD_W-1:0]  sh_height;
    logic [pmst_pkg::SEG_W-1:0]  sh_segments;
    logic [pmst_pkg::MASK_W-1:0] sh_mask;

    facet_t expected_facets[$];
    int     error_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     recv_hold;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void trig_of_phase(input logic [63:0] phase, output longint c,
                                          output longint s);
        logic [63:0] p;
        logic [1:0]  quad;
        logic [63:0] rem;
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        p = phase & 64'hFFFF;
        quad = p[15:14];
        rem = p & 64'h3FFF;
        z = longint'((rem * 64'd1686629713) >> 14);
        x = 652032874;
        y = 0;
        for (int k = 0; k < 30; k++)
        begin
            case (k)
                0: t = 843314856;
                1: t = 497837829;
                2: t = 263043836;
                3: t = 133525158;
                4: t = 67021686;
                5: t = 33543515;
                6: t = 16775850;
                7: t = 8388437;
                8: t = 4194282;
                9: t = 2097149;
                default: t = (64'sd1 <<< (30 - k)) - 1;
            endcase
            dx = shr_arith(y, k);
            dy = shr_arith(x, k);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - t;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + t;
            end
        end
        if (x > 1073741824) x = 1073741824;
        if (x < -1073741824) x = -1073741824;
        if (y > 1073741824) y = 1073741824;
        if (y < -1073741824) y = -1073741824;
        case (quad)
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endfunction

    function automatic void ring_xy(input longint r, input logic [63:0] phase,
                                    output longint px, output longint py);
        longint c;
        longint s;
        trig_of_phase(phase, c, s);
        px = shr_arith(r * c + (64'sd1 <<< 29), 30);
        py = shr_arith(r * s + (64'sd1 <<< 29), 30);
    endfunction

    function automatic facet_t make_facet(longint nx, longint ny, longint nz,
                                          longint ax, longint ay, longint bx,
                                          longint by, longint cx, longint cy,
                                          logic [2:0] zs);
        facet_t f;
        f.normal_x = nx[31:0];
        f.normal_y = ny[31:0];
        f.normal_z = nz[1:0];
        f.v0x = ax[31:0];
        f.v0y = ay[31:0];
        f.v1x = bx[31:0];
        f.v1y = by[31:0];
        f.v2x = cx[31:0];
        f.v2y = cy[31:0];
        f.z_signs = zs;
        f.config_error = 1'b0;
        f.last_of_run = 1'b0;
        return f;
    endfunction

    // Appends the facets that one segment index produces.
    function automatic void predict_segment(logic [pmst_pkg::IDX_W-1:0] seg_idx);
        logic [63:0] i;
        logic [63:0] p;
        logic [63:0] n;
        longint ix, iy, ipx, ipy, ox, oy, opx, opy, c, s;
        facet_t run[$];
        facet_t f;
        i = 64'(seg_idx);
        n = 64'(sh_segments);
        if (sh_inner == 0 || sh_outer == 0 || sh_outer < sh_inner || n < 3 || n > 4096)
        begin
            f = '0;
            f.config_error = 1'b1;
            f.last_of_run = 1'b1;
            expected_facets.push_back(f);
            return;
        end
        if (i >= n) return;
        p = (i == 0) ? n - 1 : i - 1;
        ring_xy(longint'(sh_inner), (i << 16) / n, ix, iy);
        ring_xy(longint'(sh_inner), (p << 16) / n, ipx, ipy);
        ring_xy(longint'(sh_outer), (i << 16) / n, ox, oy);
        ring_xy(longint'(sh_outer), (p << 16) / n, opx, opy);
        trig_of_phase(((2 * i + 2 * n - 1) << 16) / (2 * n), c, s);
        for (int zb = 0; zb < 2; zb++)
        begin
            if (sh_mask[zb ? 2 : 0])
                run.push_back(make_facet(0, 0, zb ? -1 : 1, 0, 0, ix, iy, ipx, ipy,
                                         zb ? 3'd7 : 3'd0));
            if (sh_mask[zb ? 3 : 1])
            begin
                run.push_back(make_facet(0, 0, zb ? -1 : 1, ix, iy, ipx, ipy, ox, oy,
                                         zb ? 3'd7 : 3'd0));
                run.push_back(make_facet(0, 0, zb ? -1 : 1, ipx, ipy, opx, opy, ox, oy,
                                         zb ? 3'd7 : 3'd0));
            end
        end
        if (sh_mask[4])
        begin
            run.push_back(make_facet(-c, -s, 0, ix, iy, ipx, ipy, ix, iy, 3'd4));
            run.push_back(make_facet(-c, -s, 0, ipx, ipy, ipx, ipy, ix, iy, 3'd6));
        end
        if (sh_mask[5])
        begin
            run.push_back(make_facet(c, s, 0, ox, oy, opx, opy, ox, oy, 3'd4));
            run.push_back(make_facet(c, s, 0, opx, opy, opx, opy, ox, oy, 3'd6));
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k]) expected_facets.push_back(run[k]);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic wait_drained();
        while (expected_facets.size() != 0) @(posedge clk);
        // The block may still be working on an index that yields nothing.
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [pmst_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = pmst_pkg::ADDR_W'({idx, 2'b00});
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            pmst_pkg::REG_INNER_RADIUS: sh_inner = value[pmst_pkg::RAD_W-1:0];
            pmst_pkg::REG_OUTER_RADIUS: sh_outer = value[pmst_pkg::RAD_W-1:0];
            pmst_pkg::REG_HEIGHT:       sh_height = value[pmst_pkg::RAD_W-1:0];
            pmst_pkg::REG_SEGMENTS:     sh_segments = value[pmst_pkg::SEG_W-1:0];
            pmst_pkg::REG_FACE_MASK:    sh_mask = value[pmst_pkg::MASK_W-1:0];
            default:                    ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_geometry(logic [31:0] r_in, logic [31:0] r_out, logic [31:0] h,
                                logic [31:0] n, logic [31:0] mask);
        write_reg(pmst_pkg::REG_INNER_RADIUS, r_in);
        write_reg(pmst_pkg::REG_OUTER_RADIUS, r_out);
        write_reg(pmst_pkg::REG_HEIGHT, h);
        write_reg(pmst_pkg::REG_SEGMENTS, n);
        write_reg(pmst_pkg::REG_FACE_MASK, mask);
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_index(logic [pmst_pkg::IDX_W-1:0] seg_idx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.segment_index = seg_idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_segment(seg_idx);
        @(negedge clk);
        in_ch.valid = 1'b0;
        in_ch.segment_index = pmst_pkg::IDX_W'($urandom);
    endtask

    function automatic logic [pmst_pkg::IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 6) return pmst_pkg::IDX_W'($urandom);
        if (r < 12)
            return (r & 1) ? pmst_pkg::IDX_W'(0) : pmst_pkg::IDX_W'(sh_segments - 1);
        return pmst_pkg::IDX_W'($urandom_range(sh_segments - 1));
    endfunction

    always @(negedge clk)
    begin
        if (recv_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        facet_t got;
        facet_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.vert0_x,
                    out_ch.vert0_y, out_ch.vert1_x, out_ch.vert1_y, out_ch.vert2_x,
                    out_ch.vert2_y, out_ch.z_signs, out_ch.config_error,
                    out_ch.last_of_run};
            if (expected_facets.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                want = expected_facets.pop_front();
                if (got.normal_x !== want.normal_x)
                    report_mismatch("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y !== want.normal_y)
                    report_mismatch("normal_y", got.normal_y, want.normal_y);
                if (got.normal_z !== want.normal_z)
                    report_mismatch("normal_z", got.normal_z, want.normal_z);
                if (got.v0x !== want.v0x) report_mismatch("vert0_x", got.v0x, want.v0x);
                if (got.v0y !== want.v0y) report_mismatch("vert0_y", got.v0y, want.v0y);
                if (got.v1x !== want.v1x) report_mismatch("vert1_x", got.v1x, want.v1x);
                if (got.v1y !== want.v1y) report_mismatch("vert1_y", got.v1y, want.v1y);
                if (got.v2x !== want.v2x) report_mismatch("vert2_x", got.v2x, want.v2x);
                if (got.v2y !== want.v2y) report_mismatch("vert2_y", got.v2y, want.v2y);
                if (got.z_signs !== want.z_signs)
                    report_mismatch("z_signs", got.z_signs, want.z_signs);
                if (got.config_error !== want.config_error)
                    report_mismatch("config_error", got.config_error, want.config_error);
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
            end
        end
    end

    task automatic test_directed();
        send_index(0);
        send_index(31);
        send_index(1);
        send_index(32);
        send_index(12'hFFF);
        wait_drained();
        set_geometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4096, 6'h3F);
        send_index(0);
        send_index(4095);
        send_index(2048);
        send_index(1024);
        wait_drained();
        set_geometry(1, 1, 0, 3, 6'h15);
        send_index(0);
        send_index(2);
        send_index(3);
        wait_drained();
        write_reg(pmst_pkg::REG_FACE_MASK, 6'h2A);
        send_index(1);
        wait_drained();
        write_reg(pmst_pkg::REG_FACE_MASK, 0);
        send_index(1);
        wait_drained();
        // Invalid geometry: each one yields a single error result.
        set_geometry(0, 100, 5, 8, 6'h3F);
        send_index(0);
        wait_drained();
        set_geometry(100, 0, 5, 8, 6'h3F);
        send_index(5);
        wait_drained();
        set_geometry(200, 100, 5, 8, 6'h3F);
        send_index(12'hFFF);
        wait_drained();
        set_geometry(100, 200, 5, 2, 6'h3F);
        send_index(0);
        wait_drained();
        set_geometry(100, 200, 5, 4097, 6'h3F);
        send_index(1);
        wait_drained();
        set_geometry(100, 200, 5, 8191, 0);
        send_index(7);
        wait_drained();
        // Writes beyond the register list are dropped.
        write_reg(3'd7, 32'hFFFF_FFFF);
        write_reg(3'd5, 32'h0);
        set_geometry(65536, 131072, 65536, 32, 6'h3F);
    endtask

    task automatic test_random_phase(int count, int idle, int stall);
        logic [31:0] r_in;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        r_in = ($urandom_range(3) == 0) ? $urandom_range(32'h7FFF_FFFF, 1)
                                        : $urandom_range(32'h0010_0000, 1);
        set_geometry(r_in,
                     ($urandom_range(9) == 0) ? $urandom_range(r_in, 1)
                                              : $urandom_range(32'h7FFF_FFFF, r_in),
                     $urandom,
                     ($urandom_range(4) == 0) ? $urandom_range(4096, 3)
                                              : $urandom_range(40, 3),
                     ($urandom_range(7) == 0) ? $urandom_range(63) : 6'h3F);
        for (int k = 0; k < count; k++)
        begin
            send_index(pick_index());
            if (k % 20 == 19)
            begin
                wait_drained();
                write_reg(pmst_pkg::REG_FACE_MASK, $urandom_range(63));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_geometry(65536, 131072, 65536, 32, 6'h3F);
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                @(negedge clk);
                recv_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 60; k++) send_index(pick_index());
            end
        join
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.segment_index = '0;
        out_ch.ready = 1'b0;
        sh_inner = pmst_pkg::RESET_INNER_RADIUS;
        sh_outer = pmst_pkg::RESET_OUTER_RADIUS;
        sh_height = pmst_pkg::RESET_HEIGHT;
        sh_segments = pmst_pkg::RESET_SEGMENTS;
        sh_mask = pmst_pkg::RESET_FACE_MASK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(75, 0, 0);
        test_random_phase(75, 62, 0);
        test_random_phase(75, 0, 62);
        test_random_phase(75, 34, 34);
        test_backpressure();
        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
